/* hw/rtl/skf_pkg.sv */
// Shared constants and controller/datapath interface types for the scalar Kalman filter.
`default_nettype none

package skf_pkg;

    localparam int DATA_W    = 16;
    localparam int NOISE_W   = 15;
    localparam int GAIN_W    = 15;
    localparam int COV_W     = 31;
    localparam int CFG_IDX_W = 1;
    localparam int DIV_STEPS = 15;
    localparam int CNT_W     = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 1'b1;

    localparam logic               OP_UPDATE  = 1'b0;
    localparam logic               OP_RESTART = 1'b1;

    localparam logic [GAIN_W-1:0]  GAIN_ONE = 15'h7FFF;
    localparam logic [COV_W-1:0]   COV_ONE  = {1'b0, GAIN_ONE, 15'h0000};

    typedef struct packed {
        logic load;
        logic pest;
        logic den;
        logic dinit;
        logic div;
        logic mulg;
        logic mulc;
        logic commit;
    } skf_cmd_t;

    typedef struct packed {
        logic restart;
        logic div_sat;
    } skf_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/skf_ctrl.sv */
// Sequencer for the scalar Kalman filter: handshakes, step order and divider count.
`default_nettype none

module skf_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire skf_pkg::skf_sts_t sts,
    output skf_pkg::skf_cmd_t     cmd
);
    import skf_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PEST  = 3'd1;
    localparam logic [2:0] ST_DEN   = 3'd2;
    localparam logic [2:0] ST_DINIT = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_MULG  = 3'd5;
    localparam logic [2:0] ST_MULC  = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_PEST;
                end
            end
            ST_PEST:
            begin
                if (sts.restart)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.pest = 1'b1;
                    state_next = ST_DEN;
                end
            end
            ST_DEN:
            begin
                cmd.den = 1'b1;
                state_next = ST_DINIT;
            end
            ST_DINIT:
            begin
                cmd.dinit = 1'b1;
                cnt_next = CNT_W'(DIV_STEPS - 1);
                state_next = sts.div_sat ? ST_MULG : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_MULG;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_MULG:
            begin
                cmd.mulg = 1'b1;
                state_next = ST_MULC;
            end
            ST_MULC:
            begin
                cmd.mulc = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/skf_dp.sv */
// Datapath for the scalar Kalman filter: filter state, noise registers, divider, multipliers.
`default_nettype none

module skf_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire skf_pkg::skf_cmd_t                 cmd,
    output skf_pkg::skf_sts_t                      sts,
    input  wire logic                              operation,
    input  wire logic signed [skf_pkg::DATA_W-1:0] sample,
    input  wire logic                              cfg_we,
    input  wire logic [skf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [skf_pkg::NOISE_W-1:0]       cfg_data,
    output logic signed [skf_pkg::DATA_W-1:0]      estimate
);
    import skf_pkg::*;

    localparam int PROD_W = GAIN_W + COV_W;

    logic [NOISE_W-1:0]        pn_reg, mn_reg;
    logic signed [DATA_W-1:0]  est_reg, est_next;
    logic [COV_W-1:0]          cov_reg, cov_next;
    logic signed [DATA_W-1:0]  out_reg;
    logic                      op_reg;
    logic signed [DATA_W-1:0]  smp_reg;
    logic [COV_W-1:0]          pest_reg, den_reg, rem_reg, rem_next;
    logic signed [DATA_W-1:0]  innov_reg;
    logic [GAIN_W-1:0]         gain_reg, gain_next;
    logic signed [31:0]        corr_prod_reg;
    logic [PROD_W-1:0]         cov_prod_reg;

    logic [COV_W:0]            pest_sum, den_sum;
    logic signed [DATA_W:0]    diff;
    logic signed [DATA_W-1:0]  innov_sat;
    logic [COV_W:0]            rem_sh;
    logic                      rem_ge;
    logic signed [DATA_W:0]    corr_wide;
    logic signed [DATA_W-1:0]  corr_sat;
    logic signed [DATA_W+1:0]  est_sum;

    function automatic logic signed [DATA_W-1:0] sat17(input logic signed [DATA_W:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[DATA_W] != v[DATA_W-1])
        begin
            r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    assign pest_sum = {1'b0, cov_reg} + {2'b00, pn_reg, 15'h0000};
    assign den_sum  = {1'b0, pest_reg} + {2'b00, mn_reg, 15'h0000};
    assign diff     = {smp_reg[DATA_W-1], smp_reg} - {est_reg[DATA_W-1], est_reg};
    assign innov_sat = sat17(diff);

    assign rem_sh   = {rem_reg, 1'b0};
    assign rem_ge   = (rem_sh >= {1'b0, den_reg});
    assign rem_next = rem_ge ? COV_W'(rem_sh - {1'b0, den_reg}) : rem_sh[COV_W-1:0];
    assign gain_next = {gain_reg[GAIN_W-2:0], rem_ge};

    assign corr_wide = corr_prod_reg[31:15];
    assign corr_sat  = sat17(corr_wide);
    assign est_sum   = {{2{est_reg[DATA_W-1]}}, est_reg} + {{2{corr_sat[DATA_W-1]}}, corr_sat};

    always_comb
    begin
        if (op_reg == OP_RESTART)
        begin
            est_next = smp_reg;
            cov_next = COV_ONE;
        end
        else
        begin
            if (est_sum[DATA_W+1:DATA_W-1] == 3'b000 || est_sum[DATA_W+1:DATA_W-1] == 3'b111)
            begin
                est_next = est_sum[DATA_W-1:0];
            end
            else
            begin
                est_next = est_sum[DATA_W+1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                             : {1'b0, {(DATA_W-1){1'b1}}};
            end
            cov_next = cov_prod_reg[PROD_W-1:15];
        end
    end

    assign sts.restart = (op_reg == OP_RESTART);
    assign sts.div_sat = (pest_reg >= den_reg);
    assign estimate    = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pn_reg  <= '0;
            mn_reg  <= '0;
            est_reg <= '0;
            cov_reg <= COV_ONE;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_PROCESS_NOISE)
            begin
                pn_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_MEASUREMENT_NOISE)
            begin
                mn_reg <= cfg_data;
            end
            if (cmd.commit)
            begin
                est_reg <= est_next;
                cov_reg <= cov_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= operation;
            smp_reg <= sample;
        end
        if (cmd.pest)
        begin
            pest_reg <= pest_sum[COV_W] ? {COV_W{1'b1}} : pest_sum[COV_W-1:0];
        end
        if (cmd.den)
        begin
            den_reg   <= den_sum[COV_W] ? {COV_W{1'b1}} : den_sum[COV_W-1:0];
            innov_reg <= innov_sat;
        end
        if (cmd.dinit)
        begin
            rem_reg  <= pest_reg;
            gain_reg <= sts.div_sat ? GAIN_ONE : '0;
        end
        if (cmd.div)
        begin
            rem_reg  <= rem_next;
            gain_reg <= gain_next;
        end
        if (cmd.mulg)
        begin
            corr_prod_reg <= $signed({17'b0, gain_reg})
                           * $signed({{16{innov_reg[DATA_W-1]}}, innov_reg});
        end
        if (cmd.mulc)
        begin
            cov_prod_reg <= PROD_W'(GAIN_ONE - gain_reg) * PROD_W'(pest_reg);
        end
        if (cmd.commit)
        begin
            out_reg <= est_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/scalar_kalman_filter_q15.sv */
// Scalar Kalman filter, Q15 estimate and Q30 covariance: top level.
//
// Usage:
//   Input words (operation, sample) arrive on in_valid/in_ready. operation 0
//   updates the estimate with the measurement in sample; operation 1 restarts
//   the filter with sample as the estimate and the covariance at one.
//   Each input word yields exactly one output word (estimate) on
//   out_valid/out_ready, in order.
//   process_noise (index 0) and measurement_noise (index 1) are written on
//   cfg_valid/cfg_ready while the filter is idle; cfg_ready is always high.
// Timing:
//   An update takes the gain from a restoring divider that produces one
//   quotient bit per cycle, then performs the two multiplies one after
//   the other and commits the output word. When the predicted covariance
//   is not below the denominator the divider is skipped. A restart skips
//   the divider and the multiplies. in_ready is high only while idle, so
//   a word is accepted only after the previous one has committed.
// Reset: estimate 0, covariance one, both noise registers 0.
// Stall: a result waits in the output register while the next word is
//   accepted and processed; that word's result holds until the slot frees.
`default_nettype none

module scalar_kalman_filter_q15 (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                operation,
    input  wire logic signed [skf_pkg::DATA_W-1:0]   sample,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [skf_pkg::DATA_W-1:0]        estimate,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [skf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [skf_pkg::NOISE_W-1:0]         cfg_data
);
    import skf_pkg::*;

    skf_cmd_t cmd;
    skf_sts_t sts;

    assign cfg_ready = 1'b1;

    skf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    skf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .operation (operation),
        .sample    (sample),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .estimate  (estimate)
    );

endmodule

`default_nettype wire

/* hw/rtl/skf_checker.sv */
// Port-level checker for the scalar Kalman filter and its bind to the top level.
`default_nettype none

module skf_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_valid,
    input wire logic                                in_ready,
    input wire logic                                operation,
    input wire logic signed [skf_pkg::DATA_W-1:0]   sample,
    input wire logic                                out_valid,
    input wire logic                                out_ready,
    input wire logic signed [skf_pkg::DATA_W-1:0]   estimate,
    input wire logic                                cfg_ready
);
    import skf_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(estimate))
        else $error("output word changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a word is in flight");

    a_restart_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && operation == OP_RESTART && !out_valid
        |-> ##3 (out_valid && estimate == $past(sample, 3)))
        else $error("restart did not return the loaded estimate");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind scalar_kalman_filter_q15 skf_checker u_skf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .sample    (sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .estimate  (estimate),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for the scalar Q15 Kalman filter with a built-in fixed-point predictor.
module tb;

    import skf_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 25;
    localparam int STALL_LEN    = 300;
    localparam int PHASES       = 15;
    localparam int PHASE_WORDS  = 117;
    localparam longint COV_MAX  = 64'h7FFF_FFFF;

    typedef struct packed {
        logic                     op;
        logic signed [DATA_W-1:0] smp;
    } kf_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic operation = OP_UPDATE;
    logic signed [DATA_W-1:0] sample = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [DATA_W-1:0] estimate;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_PROCESS_NOISE;
    logic [NOISE_W-1:0] cfg_data = '0;

    kf_word_t pend_words[$];
    logic signed [DATA_W-1:0] est_expected[$];
    int fail_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic rx_hold = 1'b0;
    event rx_stall_ev;

    // filter state as predicted
    logic signed [DATA_W-1:0] kf_est = '0;
    longint kf_cov = longint'(COV_ONE);
    logic [NOISE_W-1:0] kf_pn = '0;
    logic [NOISE_W-1:0] kf_mn = '0;

    scalar_kalman_filter_q15 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .estimate  (estimate),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic signed [DATA_W-1:0] clip16(longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[DATA_W-1:0];
    endfunction

    function automatic longint clip_cov(longint v);
        return (v > COV_MAX) ? COV_MAX : ((v < 0) ? 0 : v);
    endfunction

    function automatic logic signed [DATA_W-1:0] kf_advance(logic op,
                                                           logic signed [DATA_W-1:0] smp);
        longint g_one;
        longint p_est;
        longint denom;
        longint quo;
        longint gain;
        longint innov;
        longint corr;
        g_one = longint'(GAIN_ONE);
        if (op == OP_RESTART)
        begin
            kf_est = smp;
            kf_cov = longint'(COV_ONE);
        end
        else
        begin
            p_est = clip_cov(kf_cov + (longint'(kf_pn) << 15));
            denom = clip_cov(p_est + (longint'(kf_mn) << 15));
            if (denom <= 0)
                gain = g_one;
            else
            begin
                quo = (p_est << 15) / denom;
                gain = (quo > g_one) ? g_one : quo;
            end
            innov = clip16(longint'(smp) - longint'(kf_est));
            corr = clip16((gain * innov) >>> 15);
            kf_est = clip16(longint'(kf_est) + corr);
            kf_cov = clip_cov(((g_one - gain) * p_est) >>> 15);
        end
        return kf_est;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : word_driver
        kf_word_t nxt;
        logic took;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            took = in_valid && in_ready;
            if (took)
                est_expected.push_back(kf_advance(operation, sample));
            if (!in_valid || took)
            begin
                if (pend_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = pend_words.pop_front();
                    in_valid <= 1'b1;
                    operation <= nxt.op;
                    sample <= nxt.smp;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : estimate_monitor
        logic signed [DATA_W-1:0] want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (est_expected.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected estimate word %0d", estimate);
                end
                else
                begin
                    want = est_expected.pop_front();
                    if (estimate !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("estimate mismatch: expected %0d, got %0d", want, estimate);
                    end
                end
            end
            out_ready <= !rx_hold && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // long receiver hold-off so the filter backs up and drops in_ready
    always @(rx_stall_ev)
    begin
        rx_hold <= 1'b1;
        repeat (STALL_LEN) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin : watchdog
        int cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic push_word(logic op, logic signed [DATA_W-1:0] smp);
        kf_word_t w;
        w.op = op;
        w.smp = smp;
        pend_words.push_back(w);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [NOISE_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_PROCESS_NOISE)
            kf_pn = val;
        else
            kf_mn = val;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pend_words.size() != 0 || in_valid || est_expected.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    // mostly noisy measurements around a slowly moving level, some outliers and restarts
    task automatic fill_random(int count);
        int pick;
        int level;
        int v;
        @(negedge clk);
        level = $signed(16'($urandom));
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 19);
            if ($urandom_range(0, 31) == 0)
                level = $signed(16'($urandom));
            if (pick == 0)
                push_word(OP_RESTART, 16'($urandom));
            else if (pick == 1)
                push_word(OP_UPDATE, $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000);
            else if (pick <= 4)
                push_word(OP_UPDATE, 16'($urandom));
            else
            begin
                v = level + int'($urandom_range(0, 1023)) - 512;
                push_word(OP_UPDATE, clip16(v));
            end
        end
    endtask

    initial
    begin : stimulus
        logic [NOISE_W-1:0] pn;
        logic [NOISE_W-1:0] mn;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // zero noise: gain overflow, then zero denominator, saturating innovations
        push_word(OP_UPDATE, 16'sh7FFF);
        push_word(OP_UPDATE, 16'sh8000);
        push_word(OP_UPDATE, 16'sh8000);
        push_word(OP_RESTART, 16'sh7FFF);
        push_word(OP_UPDATE, 16'sh8000);
        push_word(OP_RESTART, 16'sh8000);
        push_word(OP_UPDATE, 16'sh7FFF);
        push_word(OP_RESTART, 16'sh0000);
        push_word(OP_UPDATE, 16'sh0001);
        push_word(OP_UPDATE, 16'shFFFF);
        push_word(OP_UPDATE, 16'sh0000);
        push_word(OP_RESTART, 16'sh5555);
        push_word(OP_UPDATE, 16'shAAAA);
        push_word(OP_RESTART, 16'shFFFF);
        push_word(OP_UPDATE, 16'sh7FFF);
        wait_idle();

        // full-scale noise: the denominator sum saturates
        write_reg(CFG_PROCESS_NOISE, 15'h7FFF);
        write_reg(CFG_MEASUREMENT_NOISE, 15'h7FFF);
        @(negedge clk);
        push_word(OP_RESTART, 16'sh0000);
        push_word(OP_UPDATE, 16'sh7FFF);
        push_word(OP_UPDATE, 16'sh8000);
        push_word(OP_UPDATE, 16'sh0064);
        push_word(OP_UPDATE, 16'shFF9C);
        push_word(OP_UPDATE, 16'sh8000);
        wait_idle();

        for (int k = 0; k < PHASES; k++)
        begin
            case (k / 5)
                0:
                begin
                    send_idle_pct = 11;
                    recv_idle_pct = 74;
                end
                1:
                begin
                    send_idle_pct = 74;
                    recv_idle_pct = 11;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (k % 5)
                0:
                begin
                    pn = '0;
                    mn = '0;
                end
                1:
                begin
                    pn = 15'h7FFF;
                    mn = 15'h7FFF;
                end
                2:
                begin
                    pn = 15'h7FFF;
                    mn = '0;
                end
                3:
                begin
                    pn = '0;
                    mn = 15'h7FFF;
                end
                default:
                begin
                    pn = $urandom_range(0, 1) ? 15'($urandom) : 15'($urandom_range(0, 63));
                    mn = $urandom_range(0, 1) ? 15'($urandom) : 15'($urandom_range(0, 1023));
                end
            endcase
            write_reg(CFG_PROCESS_NOISE, pn);
            write_reg(CFG_MEASUREMENT_NOISE, mn);
            fill_random(PHASE_WORDS / 2);
            if (k == 10)
                -> rx_stall_ev;
            wait_idle();
            fill_random(PHASE_WORDS - PHASE_WORDS / 2);
            wait_idle();
        end

        if (fail_count == 0 && est_expected.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
